/* src/hrlp_pkg.sv */
// Shared types, codes and helpers of the HTTP request line parser.
`timescale 1ns / 1ps
package hrlp_pkg;

	// Size limits of the captured fields
	localparam int PATH_SIZE   = 256;
	localparam int PROTO_SIZE  = 16;
	localparam int PATH_CNT_W  = $clog2(PATH_SIZE);
	localparam int PROTO_CNT_W = $clog2(PROTO_SIZE);

	// Result kinds
	localparam logic [1:0] KIND_PATH  = 2'd0;
	localparam logic [1:0] KIND_PROTO = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Method codes
	localparam logic [2:0] METH_UNDEF  = 3'd0;
	localparam logic [2:0] METH_GET    = 3'd1;
	localparam logic [2:0] METH_POST   = 3'd2;
	localparam logic [2:0] METH_PUT    = 3'd3;
	localparam logic [2:0] METH_DELETE = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_METHOD    = 2'd1;
	localparam logic [1:0] ST_BAD_PATH  = 2'd2;
	localparam logic [1:0] ST_BAD_PROTO = 2'd3;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_request;
	} hrlp_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [2:0] method;
		logic [1:0] status;
		logic [7:0] path_length;
		logic [3:0] protocol_length;
		logic       server_error;
	} hrlp_res_t;

	// Case-insensitive letter match against a lower-case letter
	function automatic logic is_letter(input logic [7:0] c, input logic [7:0] lower);
		return (c | 8'h20) == lower;
	endfunction

endpackage

/* src/http_request_line_parser_top.sv */
// Top level of the HTTP request line parser.
//
// Usage: request bytes enter on the req channel (req_valid / req_stall /
// req), one byte per transfer; set req.new_request on the first byte of a
// new connection. Results leave on the res channel (res_valid / res_stall /
// res): path bytes, protocol bytes, then one done record per request.
// Bytes that produce no result (method bytes, overlong fields, bytes after
// the done record) are consumed silently.
// Path: a byte transferred into the input register has its result written
// to the result buffer when the buffer has room, and shown at res from
// there. Throughput: one byte per cycle while the buffer has room, set by
// the parser step between the input register and the two-entry result buffer.
// Stall: while res_stall is high the buffer fills; once it holds two
// results, a byte in the input register is held there and req_stall rises.
// req_stall depends only on registered state.
// Reset (arst_n low): parser returns to the first method byte, the
// input register and the buffer empty; no result is pending.
`timescale 1ns / 1ps
module http_request_line_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  hrlp_pkg::hrlp_req_t req,
	output logic               res_valid,
	input  logic               res_stall,
	output hrlp_pkg::hrlp_res_t res
);
	import hrlp_pkg::*;

	hrlp_req_t item_s1;
	hrlp_res_t step_res;
	logic      valid_s1;
	logic      room;
	logic      proc;
	logic      step_emit;

	assign proc      = valid_s1 && room;
	assign req_stall = valid_s1 && !room;

	// Input register: load on transfer, drain when processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	hrlp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc),
		.req    (item_s1),
		.emit   (step_emit),
		.res    (step_res)
	);

	hrlp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (proc && step_emit),
		.push_data (step_res),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

/* src/hrlp_step.sv */
// Parser state and the per-byte decision logic of the request line parser.
`timescale 1ns / 1ps
module hrlp_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  hrlp_pkg::hrlp_req_t req,
	output logic              emit,
	output hrlp_pkg::hrlp_res_t res
);
	import hrlp_pkg::*;

	typedef enum logic [3:0] {
		PH_M0, PH_M1, PH_M2, PH_SPACE, PH_POST_T, PH_DEL_A, PH_DEL_B,
		PH_DEL_C, PH_PATH, PH_PROTO, PH_DONE
	} phase_t;

	localparam logic [PATH_CNT_W-1:0]  PATH_MAX  = PATH_CNT_W'(PATH_SIZE - 1);
	localparam logic [PROTO_CNT_W-1:0] PROTO_MAX = PROTO_CNT_W'(PROTO_SIZE - 1);

	phase_t                 phase_q, phase_e, phase_n;
	logic [2:0]             prefix_q, prefix_e, prefix_n;
	logic [2:0]             code_q, code_e, code_n;
	logic [PATH_CNT_W-1:0]  path_cnt_q, path_cnt_e, path_cnt_n;
	logic [PROTO_CNT_W-1:0] proto_cnt_q, proto_cnt_e, proto_cnt_n;
	logic                   slash_q, slash_e, slash_n;
	logic [15:0]            prior_q, prior_e, prior_n;
	logic [7:0]             c, a, b;
	logic                   done;
	logic [1:0]             done_st;

	// Restart from the reset state when a new request begins at this byte
	always_comb begin
		if (req.new_request) begin
			phase_e     = PH_M0;
			prefix_e    = METH_UNDEF;
			code_e      = METH_UNDEF;
			path_cnt_e  = '0;
			proto_cnt_e = '0;
			slash_e     = 1'b0;
			prior_e     = '0;
		end else begin
			phase_e     = phase_q;
			prefix_e    = prefix_q;
			code_e      = code_q;
			path_cnt_e  = path_cnt_q;
			proto_cnt_e = proto_cnt_q;
			slash_e     = slash_q;
			prior_e     = prior_q;
		end
	end

	assign c = req.in_byte;
	assign a = prior_e[15:8];
	assign b = prior_e[7:0];

	// Decide next state and the result of this byte
	always_comb begin
		phase_n     = phase_e;
		prefix_n    = prefix_e;
		code_n      = code_e;
		path_cnt_n  = path_cnt_e;
		proto_cnt_n = proto_cnt_e;
		slash_n     = slash_e;
		prior_n     = prior_e;
		emit        = 1'b0;
		done        = 1'b0;
		done_st     = ST_OK;
		res         = '0;
		case (phase_e)
			PH_M0, PH_M1, PH_DEL_A, PH_DEL_B: begin
				prior_n = {prior_e[7:0], c};
				case (phase_e)
					PH_M0:    phase_n = PH_M1;
					PH_M1:    phase_n = PH_M2;
					PH_DEL_A: phase_n = PH_DEL_B;
					default:  phase_n = PH_DEL_C;
				endcase
			end
			PH_M2: begin
				if (is_letter(a, CH_G) && is_letter(b, CH_E) && is_letter(c, CH_T)) begin
					prefix_n = METH_GET;
					phase_n  = PH_SPACE;
				end else if (is_letter(a, CH_P)) begin
					if (is_letter(b, CH_O) && is_letter(c, CH_S)) begin
						phase_n = PH_POST_T;
					end else if (is_letter(b, CH_U) && is_letter(c, CH_T)) begin
						prefix_n = METH_PUT;
						phase_n  = PH_SPACE;
					end else begin
						phase_n = PH_PATH;
					end
				end else if (is_letter(a, CH_D)) begin
					if (is_letter(b, CH_E) && is_letter(c, CH_L)) begin
						phase_n = PH_DEL_A;
					end else begin
						phase_n = PH_PATH;
					end
				end else begin
					done    = 1'b1;
					done_st = ST_METHOD;
				end
			end
			PH_POST_T: begin
				if (is_letter(c, CH_T)) begin
					prefix_n = METH_POST;
					phase_n  = PH_SPACE;
				end else begin
					phase_n = PH_PATH;
				end
			end
			PH_DEL_C: begin
				if (is_letter(a, CH_E) && is_letter(b, CH_T) && is_letter(c, CH_E)) begin
					prefix_n = METH_DELETE;
					phase_n  = PH_SPACE;
				end else begin
					phase_n = PH_PATH;
				end
			end
			PH_SPACE: begin
				if (c == CH_SPACE) begin
					code_n = prefix_e;
				end
				phase_n = PH_PATH;
			end
			PH_PATH: begin
				if (c == CH_SPACE) begin
					if (slash_e) begin
						phase_n = PH_PROTO;
					end else begin
						done    = 1'b1;
						done_st = ST_BAD_PATH;
					end
				end else if (c == CH_NUL || c == CH_LF) begin
					done    = 1'b1;
					done_st = ST_BAD_PATH;
				end else begin
					if (path_cnt_e == '0 && c == CH_SLASH) begin
						slash_n = 1'b1;
					end
					if (path_cnt_e < PATH_MAX) begin
						path_cnt_n   = path_cnt_e + 1'b1;
						emit         = 1'b1;
						res.kind     = KIND_PATH;
						res.out_byte = c;
					end
				end
			end
			PH_PROTO: begin
				if (c == CH_LF || c == CH_CR) begin
					done    = 1'b1;
					done_st = ST_OK;
				end else if (c == CH_NUL) begin
					done    = 1'b1;
					done_st = ST_BAD_PROTO;
				end else if (proto_cnt_e < PROTO_MAX) begin
					proto_cnt_n  = proto_cnt_e + 1'b1;
					emit         = 1'b1;
					res.kind     = KIND_PROTO;
					res.out_byte = c;
				end
			end
			default: begin
				// drop bytes after the done record
			end
		endcase

		// Build the done record from the state seen by this byte
		if (done) begin
			phase_n             = PH_DONE;
			emit                = 1'b1;
			res.kind            = KIND_DONE;
			res.out_byte        = '0;
			res.method          = code_e;
			res.status          = done_st;
			res.path_length     = 8'(path_cnt_e);
			res.protocol_length = 4'(proto_cnt_e);
			res.server_error    = (code_e == METH_UNDEF);
		end
	end

	// Hold parser state; advance on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_M0;
			prefix_q    <= METH_UNDEF;
			code_q      <= METH_UNDEF;
			path_cnt_q  <= '0;
			proto_cnt_q <= '0;
			slash_q     <= 1'b0;
			prior_q     <= '0;
		end else if (en) begin
			phase_q     <= phase_n;
			prefix_q    <= prefix_n;
			code_q      <= code_n;
			path_cnt_q  <= path_cnt_n;
			proto_cnt_q <= proto_cnt_n;
			slash_q     <= slash_n;
			prior_q     <= prior_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_parks: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit && res.kind == KIND_DONE) |=> (phase_q == PH_DONE))
		else $error("done record did not park the parser");
	a_path_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(path_cnt_q <= PATH_MAX))
		else $error("path count beyond limit");
	a_proto_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(proto_cnt_q <= PROTO_MAX))
		else $error("protocol count beyond limit");
	a_proto_slash: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PROTO) |-> slash_q)
		else $error("protocol phase reached without leading slash");
`endif

endmodule

/* src/hrlp_obuf.sv */
// Two-entry result buffer that decouples the parser from the receiver.
`timescale 1ns / 1ps
module hrlp_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hrlp_pkg::hrlp_res_t push_data,
	output logic               room,
	output logic               res_valid,
	input  logic               res_stall,
	output hrlp_pkg::hrlp_res_t res
);
	import hrlp_pkg::*;

	hrlp_res_t  slot0_q, slot1_q;
	logic [1:0] count_q;
	logic       pop;

	assign room      = (count_q != 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign res       = slot0_q;
	assign pop       = res_valid && !res_stall;

	// Track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Shift entries toward the head on each pop; a push fills the first free slot
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					slot0_q <= push_data;
				end else begin
					slot1_q <= push_data;
				end
			end
			2'b01: begin
				slot0_q <= slot1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					slot0_q <= push_data;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (room || pop))
		else $error("result buffer overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");
`endif

endmodule
